// File: sv/assert_macros.svh
// assertion macros used by uct_child_selector_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ON(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ON(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: sv/ucs_pkg.sv
// shared types and constants of the uct child selector
`default_nettype none
package ucs_pkg;
    localparam int DEF_MAX_CHILDREN = 128;
    localparam int DEF_VISIT_BITS   = 24;
    localparam logic signed [15:0] COEFF_RESET = 16'sd23167;
    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic signed [19:0] SCORE_MAX = 20'sd524287;
    localparam logic signed [19:0] SCORE_MIN = -20'sd524288;
    localparam int NUM_W = 38;

    // scoring request from selector to score unit
    typedef struct packed {
        logic               start;
        logic signed [15:0] coeff;
        logic signed [15:0] mean;
        logic [31:0]        cv;
        logic [31:0]        pv;
    } ucs_req_t;

    // scoring response
    typedef struct packed {
        logic               done;
        logic               inf;
        logic signed [19:0] score;
    } ucs_rsp_t;
endpackage
`default_nettype wire

// File: sv/ucs_score.sv
// iterative ucb1 score unit around one shared multiplier
`default_nettype none
module ucs_score
    import ucs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ucs_req_t req,
    output ucs_rsp_t      rsp
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQR  = 4'd2;
    localparam logic [3:0] S_LN   = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_TERM = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0]          state_reg;
    logic [31:0]         m_reg;
    logic [4:0]          e_reg;
    logic [15:0]         frac_reg;
    logic [5:0]          cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [32:0]         rem_reg;
    logic [NUM_W-1:0]    res_reg;
    logic [NUM_W-1:0]    bit_reg;
    logic                inf_reg;
    logic signed [19:0]  score_reg;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [32:0]         sq;
    logic [33:0]         rem_sh;
    logic [NUM_W-1:0]    trial;
    logic signed [16:0]  c17;
    logic [16:0]         coeff_abs;
    logic [20:0]         mag;
    logic signed [23:0]  term;
    logic signed [23:0]  sum;
    logic signed [19:0]  sat;

    // shared multiplier operand select
    always_comb begin
        c17 = 17'(req.coeff);
        coeff_abs = (c17 < 0) ? 17'(-c17) : 17'(c17);
        case (state_reg)
            S_SQR: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_LN: begin
                mul_a = {11'd0, e_reg, frac_reg};
                mul_b = LN2_Q30;
            end
            S_TERM: begin
                mul_a = 32'(coeff_abs);
                mul_b = 32'(res_reg[19:0]);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // per-step datapath
    always_comb begin
        sq     = mul_p[63:31];
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        trial  = res_reg + bit_reg;
        mag    = 21'((mul_p[36:0] + 37'd32768) >> 16);
        term   = c17[16] ? -24'(signed'({3'd0, mag})) : 24'(signed'({3'd0, mag}));
        sum    = 24'(req.mean) + term;
        if (sum > 24'(SCORE_MAX)) begin
            sat = SCORE_MAX;
        end else if (sum < 24'(SCORE_MIN)) begin
            sat = SCORE_MIN;
        end else begin
            sat = sum[19:0];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (req.start) begin
                        if (req.coeff == 16'sd0) begin
                            inf_reg   <= 1'b0;
                            score_reg <= 20'(req.mean);
                            state_reg <= S_DONE;
                        end else if (req.cv == 32'd0 || req.pv == 32'd0) begin
                            inf_reg   <= 1'b1;
                            score_reg <= 20'sd0;
                            state_reg <= S_DONE;
                        end else begin
                            inf_reg   <= 1'b0;
                            m_reg     <= req.pv;
                            e_reg     <= 5'd31;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // shift the leading one up to bit 31
                    if (m_reg[31]) begin
                        cnt_reg   <= 6'd15;
                        frac_reg  <= 16'd0;
                        state_reg <= S_SQR;
                    end else begin
                        m_reg <= m_reg << 1;
                        e_reg <= e_reg - 5'd1;
                    end
                end
                S_SQR: begin
                    // one fraction bit of log2 per squaring
                    if (sq[32]) begin
                        m_reg <= sq[32:1];
                    end else begin
                        m_reg <= sq[31:0];
                    end
                    frac_reg <= {frac_reg[14:0], sq[32]};
                    if (cnt_reg == 6'd0) begin
                        state_reg <= S_LN;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_LN: begin
                    num_reg   <= {mul_p[51:30], 16'd0};
                    rem_reg   <= 33'd0;
                    cnt_reg   <= 6'(NUM_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (rem_sh >= 34'(req.cv)) begin
                        rem_reg <= 33'(rem_sh - 34'(req.cv));
                        num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[32:0];
                        num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        res_reg   <= '0;
                        bit_reg   <= NUM_W'(1) << (NUM_W - 2);
                        state_reg <= S_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_SQRT: begin
                    // digit-by-digit square root
                    if (bit_reg == '0) begin
                        state_reg <= S_TERM;
                    end else begin
                        if (num_reg >= trial) begin
                            num_reg <= num_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_TERM: begin
                    score_reg <= sat;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = (state_reg == S_DONE);
    assign rsp.inf   = inf_reg;
    assign rsp.score = score_reg;
endmodule
`default_nettype wire

// File: sv/uct_child_selector_top.sv
// uct child selector: streams sibling statistics, reports the best child
// steps from input transfer to result when the coefficient or a visit count is 0: start, done,
// update; else start, n normalize steps, n = 32 - msb index of parent visits (9..32),
// 16 squarings, ln, 38 division steps, 20 root steps, term, done, update
// one child at a time, next transfer taken in the cycle after the update; a closing
// child waits while the previous result is not taken; reset: sync aresetn clears set state
`default_nettype none
`include "assert_macros.svh"
module uct_child_selector_top
    import ucs_pkg::*;
#(
    parameter int MAX_CHILDREN = DEF_MAX_CHILDREN,
    parameter int VISIT_BITS   = DEF_VISIT_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // child_mean[15:0], child_visits[39:16], parent_visits[63:40]
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // best_index[6:0], pick_score[26:7], zero fill
    output logic [31:0]      m_axis_tdata,
    // best_unbounded[0], set_overflow[1]
    output logic [1:0]       m_axis_tuser
);
    localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W = $clog2(MAX_CHILDREN);
    localparam logic [31:0] VMASK = 32'((64'd1 << VISIT_BITS) - 64'd1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_UPD  = 2'd2;

    logic [1:0]         t_state_reg;
    logic signed [15:0] coeff_reg;
    logic signed [15:0] mean_reg;
    logic [31:0]        cv_reg;
    logic [31:0]        pv_reg;
    logic               last_reg;
    logic               skip_reg;
    logic               start_reg;
    logic signed [19:0] sc_reg;
    logic               inf_reg;
    logic [CNT_W-1:0]   seen_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic signed [19:0] top_score_reg;
    logic               best_inf_reg;
    logic               m_valid_reg;
    logic [6:0]         out_idx_reg;
    logic signed [19:0] out_score_reg;
    logic               out_inf_reg;
    logic               out_ovf_reg;

    logic               take;
    logic               upd_go;
    logic               emit;
    logic               at_bound;
    logic [IDX_W-1:0]   best_idx_next;
    logic signed [19:0] top_score_next;
    logic               best_inf_next;
    logic               ovf_next;
    ucs_req_t           req;
    ucs_rsp_t           rsp;

    assign s_axis_tready = (t_state_reg == T_IDLE);
    assign upd_go = !last_reg || !m_valid_reg || m_axis_tready;
    assign emit = (t_state_reg == T_UPD) && upd_go && last_reg;
    assign at_bound = 32'(seen_reg) >= 32'(MAX_CHILDREN);

    // request to the score unit
    assign req.start = start_reg;
    assign req.coeff = coeff_reg;
    assign req.mean  = mean_reg;
    assign req.cv    = cv_reg;
    assign req.pv    = pv_reg;

    ucs_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    // keep the first strictly greatest score
    always_comb begin
        if (seen_reg == '0) begin
            take = 1'b1;
        end else if (best_inf_reg) begin
            take = 1'b0;
        end else if (inf_reg) begin
            take = 1'b1;
        end else begin
            take = sc_reg > top_score_reg;
        end
        take = take && !skip_reg;
        best_idx_next  = take ? IDX_W'(seen_reg) : best_idx_reg;
        best_inf_next  = take ? inf_reg : best_inf_reg;
        top_score_next = take ? (inf_reg ? 20'sd0 : sc_reg) : top_score_reg;
        ovf_next       = ovf_reg || skip_reg;
    end

    // control sequence and set state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_state_reg   <= T_IDLE;
            coeff_reg     <= COEFF_RESET;
            start_reg     <= 1'b0;
            seen_reg      <= '0;
            ovf_reg       <= 1'b0;
            best_idx_reg  <= '0;
            top_score_reg <= '0;
            best_inf_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            start_reg <= (t_state_reg == T_IDLE) && s_axis_tvalid && !at_bound;
            if (cfg_we) begin
                coeff_reg <= cfg_wdata;
            end
            // result valid: set on a closing child, dropped after its transfer
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (t_state_reg)
                T_IDLE: begin
                    if (s_axis_tvalid) begin
                        mean_reg <= s_axis_tdata[15:0];
                        cv_reg   <= 32'(s_axis_tdata[39:16]) & VMASK;
                        pv_reg   <= 32'(s_axis_tdata[63:40]) & VMASK;
                        last_reg <= s_axis_tlast;
                        if (at_bound) begin
                            skip_reg    <= 1'b1;
                            t_state_reg <= T_UPD;
                        end else begin
                            skip_reg    <= 1'b0;
                            t_state_reg <= T_BUSY;
                        end
                    end
                end
                T_BUSY: begin
                    if (rsp.done) begin
                        sc_reg      <= rsp.score;
                        inf_reg     <= rsp.inf;
                        t_state_reg <= T_UPD;
                    end
                end
                T_UPD: begin
                    if (upd_go) begin
                        t_state_reg <= T_IDLE;
                        if (last_reg) begin
                            // capture the result, then clear for the next set
                            out_idx_reg   <= 7'(best_idx_next);
                            out_score_reg <= best_inf_next ? SCORE_MAX : top_score_next;
                            out_inf_reg   <= best_inf_next;
                            out_ovf_reg   <= ovf_next;
                            seen_reg      <= '0;
                            ovf_reg       <= 1'b0;
                            best_idx_reg  <= '0;
                            top_score_reg <= '0;
                            best_inf_reg  <= 1'b0;
                        end else begin
                            seen_reg      <= skip_reg ? seen_reg : seen_reg + CNT_W'(1);
                            ovf_reg       <= ovf_next;
                            best_idx_reg  <= best_idx_next;
                            top_score_reg <= top_score_next;
                            best_inf_reg  <= best_inf_next;
                        end
                    end
                end
                default: begin
                    t_state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, out_score_reg, out_idx_reg};
    assign m_axis_tuser  = {out_ovf_reg, out_inf_reg};

    // checks
    `ASSERT_ON(a_done_when_busy, aclk, aresetn, rsp.done |-> t_state_reg == T_BUSY)
    `ASSERT_ON(a_last_emits, aclk, aresetn, emit |=> m_axis_tvalid)
    `ASSERT_NEVER(a_seen_bound, aclk, aresetn, 32'(seen_reg) > 32'(MAX_CHILDREN))
endmodule
`default_nettype wire
